### sv/stz_pkg.sv
package stz_pkg;

    localparam int DEPTH_BITS_DEF = 8;

    // record queue between the classifier and the output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_COMMENT = 2'd1;
    localparam logic [1:0] ERR_CLOSER  = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef struct packed {
        logic [1:0] error;
        logic       stmt_end;
        logic       tok_start;
        logic [7:0] ch;
    } t_res;

    // one or two results caused by one input word
    typedef struct packed {
        logic two;
        logic done;
        t_res r0;
        t_res r1;
    } t_rec;

endpackage

### sv/stz_front.sv
module stz_front #(
    parameter int DEPTH_BITS = stz_pkg::DEPTH_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_ch,
    input  logic         i_eos,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output stz_pkg::t_rec o_rec
);
    import stz_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    typedef struct packed {
        logic [7:0]            held;
        logic                  held_v;
        logic                  in_str;
        logic                  in_cmt;
        logic [DEPTH_BITS-1:0] depth;
        logic                  tok_open;
        logic                  sp_seen;
    } t_state;

    typedef struct packed {
        t_state     s;
        logic       two;
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_dec;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_symbol(logic [7:0] c);
        logic hit;
        case (c)
            CH_COLON, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_PCT, CH_GT,
            CH_LT, CH_BANG, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_AMP, CH_BAR,
            CH_TILDE: hit = 1'b1;
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_pair(logic [7:0] a, logic [7:0] b);
        return (a == CH_EQ    && b == CH_EQ) || (a == CH_BANG && b == CH_EQ)
            || (a == CH_BAR   && b == CH_BAR) || (a == CH_AMP && b == CH_AMP)
            || (a == CH_LT    && b == CH_EQ) || (a == CH_GT   && b == CH_EQ)
            || (a == CH_MINUS && b == CH_GT) || (a == CH_LT   && b == CH_LT)
            || (a == CH_GT    && b == CH_GT);
    endfunction

    function automatic t_res mk(logic [7:0] c, logic st, logic se, logic [1:0] er);
        t_res r;
        r.ch        = c;
        r.tok_start = st;
        r.stmt_end  = se;
        r.error     = er;
        return r;
    endfunction

    // classify byte c against the lookahead la
    function automatic t_dec decide(t_state s, logic [7:0] c, logic has_la, logic [7:0] la);
        t_dec d;
        d.s   = s;
        d.two = 1'b0;
        d.n   = 2'd0;
        d.r0  = '0;
        d.r1  = '0;
        if (s.in_cmt) begin
            if (c == CH_STAR && has_la && la == CH_SLASH) begin
                d.s.in_cmt = 1'b0;
                d.two      = 1'b1;
            end
        end else if (s.in_str) begin
            if (c == CH_QUOTE) begin
                d.n          = 2'd1;
                d.r0         = mk(c, 1'b0, 1'b0, ERR_NONE);
                d.s.in_str   = 1'b0;
                d.s.tok_open = 1'b0;
            end else if (is_space(c)) begin
                if (!s.sp_seen) begin
                    d.n  = 2'd1;
                    d.r0 = mk(CH_SPACE, 1'b0, 1'b0, ERR_NONE);
                end
                d.s.sp_seen = 1'b1;
            end else begin
                d.n         = 2'd1;
                d.r0        = mk(c, 1'b0, 1'b0, ERR_NONE);
                d.s.sp_seen = 1'b0;
            end
        end else if (is_space(c)) begin
            d.s.tok_open = 1'b0;
        end else if (c == CH_SEMI) begin
            d.n          = 2'd1;
            d.r0         = mk(c, 1'b1, s.depth == '0, ERR_NONE);
            d.s.tok_open = 1'b0;
        end else if (c == CH_QUOTE) begin
            d.n          = 2'd1;
            d.r0         = mk(c, 1'b1, 1'b0, ERR_NONE);
            d.s.in_str   = 1'b1;
            d.s.sp_seen  = 1'b0;
            d.s.tok_open = 1'b1;
        end else if (c == CH_LPAREN || c == CH_LBRACE) begin
            d.n  = 2'd1;
            d.r0 = mk(c, 1'b1, 1'b0, ERR_NONE);
            if (s.depth != DEPTH_MAX) begin
                d.s.depth = s.depth + 1'b1;
            end
            d.s.tok_open = 1'b0;
        end else if (c == CH_RPAREN || c == CH_RBRACE) begin
            d.n  = 2'd1;
            d.r0 = mk(c, 1'b1, 1'b0, (s.depth == '0) ? ERR_CLOSER : ERR_NONE);
            if (s.depth != '0) begin
                d.s.depth = s.depth - 1'b1;
            end
            d.s.tok_open = 1'b0;
        end else if (has_la && c == CH_SLASH && la == CH_STAR) begin
            d.s.in_cmt   = 1'b1;
            d.s.tok_open = 1'b0;
        end else if (has_la && c == CH_STAR && la == CH_SLASH) begin
            d.n          = 2'd1;
            d.r0         = mk(8'h00, 1'b0, 1'b0, ERR_COMMENT);
            d.two        = 1'b1;
            d.s.tok_open = 1'b0;
        end else if (has_la && is_pair(c, la)) begin
            d.n          = 2'd2;
            d.r0         = mk(c, 1'b1, 1'b0, ERR_NONE);
            d.r1         = mk(la, 1'b0, 1'b0, ERR_NONE);
            d.two        = 1'b1;
            d.s.tok_open = 1'b0;
        end else if (is_symbol(c)) begin
            d.n          = 2'd1;
            d.r0         = mk(c, 1'b1, 1'b0, ERR_NONE);
            d.s.tok_open = 1'b0;
        end else begin
            d.n          = 2'd1;
            d.r0         = mk(c, !s.tok_open, 1'b0, ERR_NONE);
            d.s.tok_open = 1'b1;
        end
        return d;
    endfunction

    t_state     r_st;
    t_state     s1;
    t_dec       d1;
    t_dec       d2;
    logic [1:0] n1;
    logic [1:0] n2;
    logic [1:0] total;
    logic       accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        d1 = decide(r_st, r_st.held, 1'b1, i_ch);
        if (r_st.held_v) begin
            s1 = d1.s;
            n1 = d1.n;
            if (d1.two) begin
                s1.held_v = 1'b0;
            end else begin
                s1.held = i_ch;
            end
        end else begin
            s1        = r_st;
            s1.held   = i_ch;
            s1.held_v = 1'b1;
            n1        = 2'd0;
        end
        // flush the held byte with no lookahead at source end
        d2    = decide(s1, s1.held, 1'b0, 8'h00);
        n2    = (i_eos && s1.held_v) ? d2.n : 2'd0;
        total = n1 + n2;

        o_rec.done = i_eos;
        o_rec.two  = (total == 2'd2);
        o_rec.r0   = (n1 != 2'd0) ? d1.r0 : d2.r0;
        o_rec.r1   = (n1 == 2'd2) ? d1.r1 : d2.r0;
        if (total == 2'd0) begin
            o_rec.r0 = '0;
        end
        o_push_valid = accept && ((total != 2'd0) || i_eos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (accept) begin
            r_st <= i_eos ? '0 : s1;
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eos |=> r_st == '0)
        else $error("state not cleared after source end");

    a_mode_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st.in_str && r_st.in_cmt))
        else $error("string and comment modes both set");

endmodule

### sv/stz_queue.sv
module stz_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  stz_pkg::t_rec i_rec,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output stz_pkg::t_rec o_rec
);
    import stz_pkg::*;

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_rec        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

### sv/stz_back.sv
module stz_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    output logic          o_pop_ready,
    input  stz_pkg::t_rec i_rec,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [7:0]    o_tdata,
    output logic [4:0]    o_tuser,
    output logic          o_tlast
);
    import stz_pkg::*;

    logic       r_sub;
    logic       r_valid;
    logic [7:0] r_tdata;
    logic [4:0] r_tuser;
    logic       r_tlast;
    logic       load;
    logic       last;
    t_res       sel;

    assign load        = i_pop_valid && (!r_valid || i_tready);
    assign sel         = r_sub ? i_rec.r1 : i_rec.r0;
    assign last        = r_sub || !i_rec.two;
    // release the record once its final word is loaded
    assign o_pop_ready = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_sub   <= !r_sub && i_rec.two;
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_tdata <= sel.ch;
            r_tuser <= {i_rec.done && last, sel.error, sel.stmt_end, sel.tok_start};
            r_tlast <= last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

    a_sub_has_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> i_pop_valid && i_rec.two)
        else $error("second word pending without a two-word record");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_tuser[4] |-> r_tlast)
        else $error("source end flagged on a word that is not last of its run");

endmodule

### sv/statement_tokenizer.sv
// Byte tokenizer for statement-oriented source text.
// Input stream: one source byte per word on i_s_axis_tdata; i_s_axis_tlast
// marks the final byte of the source. Output stream: one kept token byte per
// word, with token start, statement end, error code and source-end flags in
// o_m_axis_tuser; o_m_axis_tlast marks the last word caused by an input word.
// Each byte but a source's last is held until the next one arrives and is
// decided with it as lookahead, so its words leave after that byte is taken.
// A front classifier decides one input word per cycle and writes at most one
// record (up to two output words) into a four-entry queue; an output stage
// drains the queue one word per cycle while the receiver is ready. Input words
// are taken every cycle while the queue has room; a record of two words (a
// two-character operator, or a final flush) is popped once both are loaded.
// A record enters the queue when the input word that caused it is accepted;
// the output stage then registers its first word, and any second word after it.
// Reset (synchronous, active low) clears the lookahead, string, comment and
// nesting state and empties the queue. When the receiver stalls, the output
// word holds, the queue fills, and then o_s_axis_tready drops.
module statement_tokenizer #(
    parameter int DEPTH_BITS = stz_pkg::DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] ch
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic [4:0] o_m_axis_tuser,   // [0] token_start, [1] statement_end,
                                         // [3:2] error, [4] source_done
    output logic       o_m_axis_tlast
);
    import stz_pkg::*;

    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;
    t_rec rec_in;
    t_rec rec_out;

    stz_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_ch         (i_s_axis_tdata),
        .i_eos        (i_s_axis_tlast),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_rec        (rec_in)
    );

    stz_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_rec        (rec_in),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_rec        (rec_out)
    );

    stz_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_rec       (rec_out),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule

### sim/stz_word_checker.sv
module stz_word_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] ch
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,   // [7:0] out_char
    input  logic [4:0] i_out_user,   // [0] token_start, [1] statement_end,
                                     // [3:2] error, [4] source_done
    input  logic       i_out_last,
    output int         o_pending,
    output int         o_fails,
    output int         o_checked,
    output int         o_flagged
);
    import stz_pkg::*;

    localparam int DEPTH_W = DEPTH_BITS_DEF;
    localparam int MAX_PRINTS = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       tok_start;
        logic       stmt_end;
        logic [1:0] error;
        logic       run_last;
        logic       src_done;
    } t_tok_word;

    t_tok_word token_words[$];
    t_tok_word step_words[2];
    int        step_n;
    int        fail_cnt = 0;
    int        checked_cnt = 0;
    int        flagged_cnt = 0;

    logic [7:0]         held_ch;
    logic               held_valid;
    logic               in_string;
    logic               in_comment;
    logic [DEPTH_W-1:0] depth;
    logic               tok_open;
    logic               str_space;

    function automatic void clear_state();
        held_ch    = 8'h00;
        held_valid = 1'b0;
        in_string  = 1'b0;
        in_comment = 1'b0;
        depth      = '0;
        tok_open   = 1'b0;
        str_space  = 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_single_symbol(input logic [7:0] c);
        case (c)
            CH_COLON, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_PCT, CH_GT,
            CH_LT, CH_BANG, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_AMP, CH_BAR,
            CH_TILDE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_op_pair(input logic [7:0] a, input logic [7:0] b);
        case ({a, b})
            {CH_EQ, CH_EQ}, {CH_BANG, CH_EQ}, {CH_BAR, CH_BAR}, {CH_AMP, CH_AMP},
            {CH_LT, CH_EQ}, {CH_GT, CH_EQ}, {CH_MINUS, CH_GT}, {CH_LT, CH_LT},
            {CH_GT, CH_GT}: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit_word(input logic [7:0] c, input logic st,
                                      input logic se, input logic [1:0] er);
        if (step_n < 2) begin
            step_words[step_n] = '{c, st, se, er, 1'b0, 1'b0};
            step_n++;
        end
    endfunction

    // decide one byte with optional lookahead; returns bytes consumed
    function automatic int decide_byte(input logic [7:0] c, input bit has_la,
                                       input logic [7:0] la);
        if (in_comment) begin
            if (c == CH_STAR && has_la && la == CH_SLASH) begin
                in_comment = 1'b0;
                return 2;
            end
            return 1;
        end
        if (in_string) begin
            if (c == CH_QUOTE) begin
                emit_word(c, 1'b0, 1'b0, ERR_NONE);
                in_string = 1'b0;
                tok_open  = 1'b0;
            end else if (is_blank(c)) begin
                // fold a whitespace run to one space
                if (!str_space) emit_word(CH_SPACE, 1'b0, 1'b0, ERR_NONE);
                str_space = 1'b1;
            end else begin
                emit_word(c, 1'b0, 1'b0, ERR_NONE);
                str_space = 1'b0;
            end
            return 1;
        end
        if (is_blank(c)) begin
            tok_open = 1'b0;
            return 1;
        end
        if (c == CH_SEMI) begin
            emit_word(c, 1'b1, depth == '0, ERR_NONE);
            tok_open = 1'b0;
            return 1;
        end
        if (c == CH_QUOTE) begin
            emit_word(c, 1'b1, 1'b0, ERR_NONE);
            in_string = 1'b1;
            str_space = 1'b0;
            tok_open  = 1'b1;
            return 1;
        end
        if (c == CH_LPAREN || c == CH_LBRACE) begin
            emit_word(c, 1'b1, 1'b0, ERR_NONE);
            if (depth != '1) depth++;
            tok_open = 1'b0;
            return 1;
        end
        if (c == CH_RPAREN || c == CH_RBRACE) begin
            emit_word(c, 1'b1, 1'b0, (depth == '0) ? ERR_CLOSER : ERR_NONE);
            if (depth != '0) depth--;
            tok_open = 1'b0;
            return 1;
        end
        if (has_la && c == CH_SLASH && la == CH_STAR) begin
            // only the slash is consumed; the star is read inside the comment
            in_comment = 1'b1;
            tok_open   = 1'b0;
            return 1;
        end
        if (has_la && c == CH_STAR && la == CH_SLASH) begin
            emit_word(8'h00, 1'b0, 1'b0, ERR_COMMENT);
            tok_open = 1'b0;
            return 2;
        end
        if (has_la && is_op_pair(c, la)) begin
            emit_word(c, 1'b1, 1'b0, ERR_NONE);
            emit_word(la, 1'b0, 1'b0, ERR_NONE);
            tok_open = 1'b0;
            return 2;
        end
        if (is_single_symbol(c)) begin
            emit_word(c, 1'b1, 1'b0, ERR_NONE);
            tok_open = 1'b0;
            return 1;
        end
        emit_word(c, !tok_open, 1'b0, ERR_NONE);
        tok_open = 1'b1;
        return 1;
    endfunction

    function automatic void tokenize_word(input logic [7:0] b, input logic eos);
        step_n = 0;
        if (held_valid) begin
            if (decide_byte(held_ch, 1'b1, b) == 2) held_valid = 1'b0;
            else held_ch = b;
        end else begin
            held_ch    = b;
            held_valid = 1'b1;
        end
        if (eos) begin
            // flush the held byte with no lookahead
            if (held_valid) void'(decide_byte(held_ch, 1'b0, 8'h00));
            if (step_n == 0) emit_word(8'h00, 1'b0, 1'b0, ERR_NONE);
            clear_state();
        end
        if (step_n > 0) begin
            step_words[step_n-1].run_last = 1'b1;
            if (eos) step_words[step_n-1].src_done = 1'b1;
        end
        for (int k = 0; k < step_n; k++) token_words = {token_words, step_words[k]};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_cnt++;
        if (fail_cnt <= MAX_PRINTS)
            $display("mismatch on output word %0d: %s got 0x%0h, want 0x%0h",
                     checked_cnt, what, got, want);
    endtask

    task automatic check_word();
        t_tok_word want;
        if (token_words.size() == 0) begin
            report_mismatch("word with nothing pending, out_char", int'(i_out_data), 0);
        end else begin
            want = token_words.pop_front();
            if (i_out_data != want.ch)
                report_mismatch("out_char", int'(i_out_data), int'(want.ch));
            if (i_out_user[0] != want.tok_start)
                report_mismatch("token_start", int'(i_out_user[0]), int'(want.tok_start));
            if (i_out_user[1] != want.stmt_end)
                report_mismatch("statement_end", int'(i_out_user[1]), int'(want.stmt_end));
            if (i_out_user[3:2] != want.error)
                report_mismatch("error", int'(i_out_user[3:2]), int'(want.error));
            if (i_out_user[4] != want.src_done)
                report_mismatch("source_done", int'(i_out_user[4]), int'(want.src_done));
            if (i_out_last != want.run_last)
                report_mismatch("final_of_run", int'(i_out_last), int'(want.run_last));
        end
        if (i_out_user[1] || i_out_user[3:2] != ERR_NONE) flagged_cnt++;
        checked_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            token_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_word();
            if (i_in_valid && i_in_ready) tokenize_word(i_in_data, i_in_last);
        end
        o_pending <= token_words.size();
        o_fails   <= fail_cnt;
        o_checked <= checked_cnt;
        o_flagged <= flagged_cnt;
    end

endmodule

### sim/tb_statement_tokenizer.sv
module tb_statement_tokenizer;
    import stz_pkg::*;

    localparam int WORD_TARGET = 1050;
    localparam int DEEP_START  = 500;
    localparam int DEEP_OPENS  = 260;
    localparam int HOLD_AFTER  = 300;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       stall_on = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic [4:0] m_user;
    logic       m_last;

    int pending;
    int fails;
    int checked;
    int flagged;
    int words_sent = 0;
    int sources_sent = 0;
    bit tx_calm = 1'b0;

    logic [7:0] src_bytes[$];

    string ident_chars = "abcdefxyzQRZ0189_";
    string pair_ops    = "==!=||&&<=>=-><<>>";
    string symbols     = ":+-*/=%><![],&|~";
    string brackets    = "(){}[]";
    string blanks      = " \t\n\013\014\r";

    statement_tokenizer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    stz_word_checker u_word_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_data   (s_data),
        .i_in_last   (s_last),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_out_user  (m_user),
        .i_out_last  (m_last),
        .o_pending   (pending),
        .o_fails     (fails),
        .o_checked   (checked),
        .o_flagged   (flagged)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_word(input logic [7:0] c, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= last;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        words_sent++;
        if (last) sources_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_source();
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < src_bytes.size(); i++)
            send_word(src_bytes[i], i == src_bytes.size() - 1);
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_byte(input logic [7:0] c);
        src_bytes = {src_bytes, c};
    endtask

    task automatic push_blanks();
        repeat ($urandom_range(1, 3)) add_byte(pick(blanks));
    endtask

    task automatic build_source();
        int         kind;
        int         k;
        logic [7:0] c;
        src_bytes.delete();
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 19);
            if (kind <= 3) begin
                repeat ($urandom_range(1, 5)) add_byte(pick(ident_chars));
            end else if (kind <= 6) begin
                push_blanks();
            end else if (kind <= 8) begin
                k = $urandom_range(0, 8);
                add_byte(pair_ops[2*k]);
                add_byte(pair_ops[2*k+1]);
            end else if (kind <= 10) begin
                add_byte(pick(symbols));
            end else if (kind <= 12) begin
                add_byte(pick(brackets));
            end else if (kind == 13) begin
                add_byte(CH_SEMI);
            end else if (kind <= 15) begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        push_blanks();
                    end else begin
                        c = 8'($urandom_range(33, 126));
                        if (c == CH_QUOTE) c = CH_PLUS;
                        add_byte(c);
                    end
                end
                // leave some strings open to the end of the source
                if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
            end else if (kind == 16) begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end else if (kind == 17) begin
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 1) == 0) add_byte(CH_SEMI);
    endtask

    // drive the nesting depth past its saturation point and three levels back down
    task automatic build_deep_source();
        src_bytes.delete();
        repeat (DEEP_OPENS) add_byte(CH_LPAREN);
        add_byte(CH_COLON);
        add_byte(CH_SEMI);
        repeat (3) add_byte(CH_RPAREN);
        add_byte(CH_SEMI);
    endtask

    initial begin
        int taken;
        int hold;
        bit rx_calm;
        taken = 0;
        hold = 0;
        rx_calm = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (m_ready && m_valid) begin
                taken++;
                if (taken % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
                hold = rx_calm ? 0 : $urandom_range(0, 10);
            end else if (hold > 0) begin
                hold--;
            end
            m_ready <= !stall_on && hold == 0;
        end
    end

    // long receiver hold-off while input keeps coming
    initial begin
        wait (words_sent >= HOLD_AFTER);
        @(posedge clk);
        stall_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        stall_on <= 1'b0;
    end

    initial begin
        #(12 * 600000);
        $display("timeout: %0d words still pending", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        bit deep_done;
        deep_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("a/*/b");
        send_text("x\"a \t b\"");
        send_text(")*/;");
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_text(" ");
        send_text("\"q");
        send_text("/*");

        while (words_sent < WORD_TARGET) begin
            if (!deep_done && words_sent >= DEEP_START) begin
                build_deep_source();
                deep_done = 1'b1;
            end else begin
                build_source();
            end
            send_source();
        end
        s_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d sources and %0d input words, including nesting saturation",
                 sources_sent, words_sent);
        $display("and a long output stall; %0d output words checked, %0d with a flag set.",
                 checked, flagged);
        if (fails == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### statement_tokenizer.f
sv/stz_pkg.sv
sv/stz_front.sv
sv/stz_queue.sv
sv/stz_back.sv
sv/statement_tokenizer.sv
sim/stz_word_checker.sv
sim/tb_statement_tokenizer.sv
